// ===== rtl/pwfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pwfr_pkg
// Shared types, constants and the parity check for the pulse width frame
// receiver.
// ----------------------------------------------------------------------------
package pwfr_pkg;

    localparam int TICK_W      = 16;
    localparam int SHIFT_W     = 64;
    localparam int COUNT_W     = 7;
    localparam int PAYLOAD_W   = 60;
    localparam int NIBCNT_W    = 5;
    localparam int ERR_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_NIBBLES = 16;

    localparam logic [COUNT_W-1:0]  MAX_BITS   = COUNT_W'(MAX_NIBBLES * 4);
    localparam logic [COUNT_W-1:0]  COUNT_SAT  = {COUNT_W{1'b1}};
    localparam logic [TICK_W-1:0]   TICK_SAT   = {TICK_W{1'b1}};
    localparam logic [NIBCNT_W-1:0] NIB_SAT    = NIBCNT_W'(16);

    localparam logic [TICK_W-1:0] ZERO_MIN_RESET = 16'd600;
    localparam logic [TICK_W-1:0] ONE_MIN_RESET  = 16'd1400;
    localparam logic [TICK_W-1:0] END_GAP_RESET  = 16'd4000;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_GAP  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_BITS  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_ALIGN    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_PARITY   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG = 3'd4;

    localparam logic [3:0] NIB_MASK = 4'hF;

    typedef struct packed {
        logic [TICK_W-1:0] zero_min;
        logic [TICK_W-1:0] one_min;
        logic [TICK_W-1:0] end_gap;
    } cfg_t;

    typedef struct packed {
        logic               close;
        logic [SHIFT_W-1:0] shift_bits;
        logic [COUNT_W-1:0] bit_count;
        logic               overlong;
    } frame_snap_t;

    function automatic logic parity_ok(input logic [SHIFT_W-1:0] v);
        logic [3:0] x;
        x = 4'd0;
        for (int i = 1; i < SHIFT_W / 4; i++) begin
            x = x ^ v[4*i +: 4];
        end
        return ((x + 4'd1) & NIB_MASK) == v[3:0];
    endfunction

endpackage

// ===== rtl/pwfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pwfr_cfg_regs
// Timing threshold registers written through the configuration channel.
// ----------------------------------------------------------------------------
module pwfr_cfg_regs
    import pwfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_min <= ZERO_MIN_RESET;
            cfg_reg.one_min  <= ONE_MIN_RESET;
            cfg_reg.end_gap  <= END_GAP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ZERO_MIN: cfg_reg.zero_min <= cfg_data;
                REG_ONE_MIN:  cfg_reg.one_min  <= cfg_data;
                REG_END_GAP:  cfg_reg.end_gap  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/pwfr_frame_track.sv =====
// ----------------------------------------------------------------------------
// pwfr_frame_track
// Frame timer and bit decoder: tracks the line, times the low pulses and
// shifts in decoded bits, flagging the tick that closes a frame.
// ----------------------------------------------------------------------------
module pwfr_frame_track
    import pwfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        line_level,
    input  cfg_t        cfg,
    output frame_snap_t snap
);

    logic               in_frame_reg,  in_frame_next;
    logic [TICK_W-1:0]  elapsed_reg,   elapsed_next;
    logic               bit_taken_reg, bit_taken_next;
    logic [SHIFT_W-1:0] shift_reg,     shift_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic               overlong_reg,  overlong_next;

    logic [TICK_W-1:0] elapsed_inc;
    logic              close;
    logic              is_zero;
    logic              is_one;

    assign elapsed_inc = (elapsed_reg == TICK_SAT) ? elapsed_reg : elapsed_reg + 16'd1;
    assign close       = in_frame_reg && (elapsed_inc >= cfg.end_gap);
    assign is_zero     = (elapsed_inc > cfg.zero_min) && (elapsed_inc < cfg.one_min);
    assign is_one      = elapsed_inc > cfg.one_min;

    assign snap.close      = close;
    assign snap.shift_bits = shift_reg;
    assign snap.bit_count  = count_reg;
    assign snap.overlong   = overlong_reg;

    always_comb begin
        in_frame_next  = in_frame_reg;
        elapsed_next   = elapsed_reg;
        bit_taken_next = bit_taken_reg;
        shift_next     = shift_reg;
        count_next     = count_reg;
        overlong_next  = overlong_reg;
        if (accept) begin
            if (!in_frame_reg) begin
                if (!line_level) begin
                    in_frame_next  = 1'b1;
                    elapsed_next   = '0;
                    bit_taken_next = 1'b0;
                    shift_next     = '0;
                    count_next     = '0;
                    overlong_next  = 1'b0;
                end
            end else begin
                elapsed_next = elapsed_inc;
                if (close) begin
                    in_frame_next = 1'b0;
                end else begin
                    // decode on first high after a low
                    if (line_level && !bit_taken_reg && (is_zero || is_one)) begin
                        if (count_reg >= MAX_BITS) begin
                            overlong_next = 1'b1;
                        end
                        shift_next     = {shift_reg[SHIFT_W-2:0], is_one};
                        count_next     = (count_reg == COUNT_SAT) ? count_reg
                                                                  : count_reg + 7'd1;
                        bit_taken_next = 1'b1;
                    end
                    if (bit_taken_reg && !line_level) begin
                        bit_taken_next = 1'b0;
                        elapsed_next   = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            elapsed_reg   <= '0;
            bit_taken_reg <= 1'b0;
            shift_reg     <= '0;
            count_reg     <= '0;
            overlong_reg  <= 1'b0;
        end else begin
            in_frame_reg  <= in_frame_next;
            elapsed_reg   <= elapsed_next;
            bit_taken_reg <= bit_taken_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            overlong_reg  <= overlong_next;
        end
    end

endmodule

// ===== rtl/pwfr_result_stage.sv =====
// ----------------------------------------------------------------------------
// pwfr_result_stage
// Frame checks (length, alignment, parity) and the registered result word
// with its valid/ready handshake.
// ----------------------------------------------------------------------------
module pwfr_result_stage
    import pwfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  frame_snap_t          snap,
    output logic                 space,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PAYLOAD_W-1:0] m_payload,
    output logic                 m_frame_ok,
    output logic [ERR_W-1:0]     m_error_code,
    output logic [NIBCNT_W-1:0]  m_nibble_count
);

    logic                 valid_reg,   valid_next;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic                 ok_reg;
    logic [ERR_W-1:0]     err_reg;
    logic [NIBCNT_W-1:0]  nib_reg;

    logic [ERR_W-1:0]    err;
    logic [NIBCNT_W-1:0] nib;
    logic                load;

    assign load  = accept && snap.close;
    assign space = !valid_reg || m_ready;
    assign nib   = (snap.bit_count[COUNT_W-1:2] > NIB_SAT) ? NIB_SAT
                                                            : snap.bit_count[COUNT_W-1:2];

    always_comb begin
        if (snap.bit_count == '0) begin
            err = ERR_NO_BITS;
        end else if (snap.overlong) begin
            err = ERR_TOO_LONG;
        end else if (snap.bit_count[1:0] != 2'd0) begin
            err = ERR_ALIGN;
        end else if (!parity_ok(snap.shift_bits)) begin
            err = ERR_PARITY;
        end else begin
            err = ERR_OK;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            payload_reg <= (err == ERR_OK) ? snap.shift_bits[SHIFT_W-1:4] : '0;
            ok_reg      <= (err == ERR_OK);
            err_reg     <= err;
            nib_reg     <= nib;
        end
    end

    assign m_valid        = valid_reg;
    assign m_payload      = payload_reg;
    assign m_frame_ok     = ok_reg;
    assign m_error_code   = err_reg;
    assign m_nibble_count = nib_reg;

endmodule

// ===== rtl/pulse_width_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// pulse_width_frame_receiver
// Receives pulse width coded frames from a sampled line and checks nibble
// parity.
//
// Usage:
//   s_ channel: one sampled line level word per tick (s_line_level).
//   m_ channel: one result word per closed frame: payload without the
//   parity nibble, frame_ok, error_code and nibble_count.
//   cfg channel: writes zero_min (0), one_min (1) and end_gap (2) ticks;
//   always ready; must be written only while the receiver is idle, which the
//   block does not enforce. Throughput: one line word per cycle while s_ready
//   is high. Frame state updates in the cycle the word is taken; the result
//   word is registered and shows on m_valid the cycle after the closing word.
//   Reset (aresetn low, synchronous): receiver idle, timers and shift state
//   cleared, thresholds back to 600, 1400 and 4000 ticks, no result pending.
//   Stall: while a result word waits and m_ready is low, s_ready is low;
//   the output register frees as soon as the word is taken.
// ----------------------------------------------------------------------------
module pulse_width_frame_receiver
    import pwfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_line_level,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PAYLOAD_W-1:0] m_payload,
    output logic                 m_frame_ok,
    output logic [ERR_W-1:0]     m_error_code,
    output logic [NIBCNT_W-1:0]  m_nibble_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    cfg_t        cfg;
    frame_snap_t snap;
    logic        space;
    logic        accept;

    assign s_ready = space;
    assign accept  = s_valid && space;

    pwfr_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwfr_frame_track u_frame_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .line_level (s_line_level),
        .cfg        (cfg),
        .snap       (snap)
    );

    pwfr_result_stage u_result_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .snap           (snap),
        .space          (space),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .m_frame_ok     (m_frame_ok),
        .m_error_code   (m_error_code),
        .m_nibble_count (m_nibble_count)
    );

endmodule
